// ----- rtl/core/rle_image_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// rle_image_decoder_assert.svh
// Assertion macros shared by the run-length decoder modules.
// ----------------------------------------------------------------------------
`ifndef RLE_IMAGE_DECODER_ASSERT_SVH
`define RLE_IMAGE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RLE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rle decoder check failed");

// next-cycle implication
`define RLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rle decoder check failed");

`else

`define RLE_ASSERT_SAME(label, ante, cons)
`define RLE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/rle_dec_pkg.sv -----
// ----------------------------------------------------------------------------
// rle_dec_pkg
// Types and constants of the run-length image decoder.
// ----------------------------------------------------------------------------
package rle_dec_pkg;

	typedef enum logic [1:0] {
		PH_CTRL = 2'd0,
		PH_RUN  = 2'd1,
		PH_LIT  = 2'd2,
		PH_SKIP = 2'd3
	} phase_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EARLY = 2'd1;
	localparam logic [1:0] ST_CLIP  = 2'd2;

	localparam logic       REG_IMAGE_WIDTH  = 1'b0;
	localparam logic       REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [7:0] RUN_BIAS = 8'h7F;

	localparam int unsigned CFG_W = 11;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd200;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic [7:0] repeat_count;
		logic       image_done;
		logic [1:0] status;
	} desc_t;

endpackage

// ----- rtl/core/rle_dec_core.sv -----
// ----------------------------------------------------------------------------
// rle_dec_core
// Decode stage: control-byte parsing, pixel counting and descriptor forming.
// ----------------------------------------------------------------------------
`include "rle_image_decoder_assert.svh"

module rle_dec_core #(
	parameter int unsigned PW = 22
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          data_byte,
	input  logic                source_exhausted,
	input  logic [PW-1:0]       total,
	output logic                emit,
	output rle_dec_pkg::desc_t  desc
);

	rle_dec_pkg::phase_t phase_q, phase_d;
	logic [7:0]    pend_q, pend_d;
	logic [PW-1:0] pd_q, pd_d;

	logic [PW-1:0] left, want, cnt, pd_sum;
	logic [7:0]    rest;
	logic          clip, done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rle_dec_pkg::PH_CTRL;
			pend_q  <= '0;
			pd_q    <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			pd_q    <= pd_d;
		end
	end

	// pixel budget for a run or one literal
	always_comb begin
		left   = (total > pd_q) ? (total - pd_q) : '0;
		want   = (phase_q == rle_dec_pkg::PH_RUN) ? PW'(pend_q) : PW'(1);
		clip   = want > left;
		cnt    = clip ? left : want;
		pd_sum = pd_q + cnt;
		done   = pd_sum >= total;
		rest   = (pend_q != 8'd0) ? (pend_q - 8'd1) : 8'd0;
	end

	always_comb begin
		phase_d = phase_q;
		pend_d  = pend_q;
		pd_d    = pd_q;
		emit    = 1'b0;
		desc    = '{pixel_value: data_byte, repeat_count: cnt[7:0], image_done: done,
			status: clip ? rle_dec_pkg::ST_CLIP : rle_dec_pkg::ST_OK};
		if (source_exhausted) begin
			phase_d = rle_dec_pkg::PH_CTRL;
			pend_d  = '0;
			pd_d    = '0;
			emit    = (phase_q != rle_dec_pkg::PH_SKIP);
			desc    = '{pixel_value: 8'd0, repeat_count: 8'd0, image_done: 1'b1,
				status: rle_dec_pkg::ST_EARLY};
		end else begin
			case (phase_q)
				rle_dec_pkg::PH_CTRL: begin
					if (data_byte > rle_dec_pkg::RUN_BIAS) begin
						pend_d  = data_byte - rle_dec_pkg::RUN_BIAS;
						phase_d = rle_dec_pkg::PH_RUN;
					end else begin
						pend_d  = data_byte + 8'd1;
						phase_d = rle_dec_pkg::PH_LIT;
					end
				end
				rle_dec_pkg::PH_RUN: begin
					emit    = 1'b1;
					phase_d = rle_dec_pkg::PH_CTRL;
					pend_d  = '0;
					pd_d    = done ? '0 : pd_sum;
				end
				rle_dec_pkg::PH_LIT: begin
					emit   = 1'b1;
					pend_d = rest;
					if (done) begin
						pd_d    = '0;
						phase_d = (rest != 8'd0) ? rle_dec_pkg::PH_SKIP : rle_dec_pkg::PH_CTRL;
						if (rest != 8'd0)
							desc.status = rle_dec_pkg::ST_CLIP;
					end else begin
						pd_d = pd_sum;
						if (rest == 8'd0)
							phase_d = rle_dec_pkg::PH_CTRL;
					end
				end
				rle_dec_pkg::PH_SKIP: begin
					pend_d = rest;
					if (rest == 8'd0)
						phase_d = rle_dec_pkg::PH_CTRL;
				end
				default: begin
					phase_d = rle_dec_pkg::PH_CTRL;
				end
			endcase
		end
	end

	`RLE_ASSERT_SAME(a_lit_pending, phase_q == rle_dec_pkg::PH_LIT, pend_q != 8'd0)
	`RLE_ASSERT_SAME(a_skip_pending, phase_q == rle_dec_pkg::PH_SKIP, pend_q != 8'd0)
	`RLE_ASSERT_NEXT(a_done_clears, fire && emit && desc.image_done, pd_q == '0)

endmodule

// ----- rtl/core/rle_image_decoder.sv -----
// ----------------------------------------------------------------------------
// rle_image_decoder
// Run-length image decoder: compressed bytes in, (value, count) runs out.
// ----------------------------------------------------------------------------
// Input channel: byte_valid / byte_stall carry one compressed word per cycle while unstalled
// (data_byte, source_exhausted). Output channel: desc_valid / desc_stall
// carry one run descriptor (pixel_value, repeat_count, image_done, status).
// Control bytes and dropped surplus literals produce no descriptor.
// A byte is taken into the input register when it is accepted, and is decoded
// from there into the output register, where its descriptor is presented.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single decode stage whose phase, pending count and pixel counter update on each byte it decodes.
// Image size comes from cfg writes (index 0 width, index 1 height); the
// pixel total is multiplied out at the write.
// Reset: 320 x 200 image, decoder expects a control byte, no word in flight.
// When desc_stall is high the descriptor holds; the input register keeps or takes
// one byte, and byte_stall is high while it holds one, until the output frees up.
// ----------------------------------------------------------------------------
`include "rle_image_decoder_assert.svh"

module rle_image_decoder #(
	parameter int unsigned MAX_DIMENSION = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        source_exhausted,
	output logic        desc_valid,
	input  logic        desc_stall,
	output logic [7:0]  pixel_value,
	output logic [7:0]  repeat_count,
	output logic        image_done,
	output logic [1:0]  status
);

	localparam int unsigned DW = $clog2(MAX_DIMENSION + 1);
	localparam int unsigned TW = 2 * DW;

	function automatic logic [DW-1:0] clamp_dim(input logic [rle_dec_pkg::CFG_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w == 32'd0)
			w = 32'd1;
		else if (w > 32'(MAX_DIMENSION))
			w = 32'(MAX_DIMENSION);
		return w[DW-1:0];
	endfunction

	logic [DW-1:0] wdim_q, hdim_q;
	logic [TW-1:0] total_q;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          exh_s1;
	logic          advance, accept, emit;
	rle_dec_pkg::desc_t desc, desc_q;
	logic          out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wdim_q  <= clamp_dim(rle_dec_pkg::WIDTH_RESET);
			hdim_q  <= clamp_dim(rle_dec_pkg::HEIGHT_RESET);
			total_q <= TW'(clamp_dim(rle_dec_pkg::WIDTH_RESET))
				* TW'(clamp_dim(rle_dec_pkg::HEIGHT_RESET));
		end else if (cfg_we) begin
			case (cfg_index)
				rle_dec_pkg::REG_IMAGE_WIDTH: begin
					wdim_q  <= clamp_dim(cfg_data);
					total_q <= TW'(clamp_dim(cfg_data)) * TW'(hdim_q);
				end
				rle_dec_pkg::REG_IMAGE_HEIGHT: begin
					hdim_q  <= clamp_dim(cfg_data);
					total_q <= TW'(wdim_q) * TW'(clamp_dim(cfg_data));
				end
				default: begin
					wdim_q <= wdim_q;
				end
			endcase
		end
	end

	assign advance    = !out_valid_q || !desc_stall;
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			exh_s1  <= source_exhausted;
		end
	end

	rle_dec_core #(
		.PW(TW)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (valid_s1 && advance),
		.data_byte        (byte_s1),
		.source_exhausted (exh_s1),
		.total            (total_q),
		.emit             (emit),
		.desc             (desc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1 && emit;
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit)
			desc_q <= desc;
	end

	assign desc_valid   = out_valid_q;
	assign pixel_value  = desc_q.pixel_value;
	assign repeat_count = desc_q.repeat_count;
	assign image_done   = desc_q.image_done;
	assign status       = desc_q.status;

	`RLE_ASSERT_SAME(a_ok_has_pixels, out_valid_q && status == rle_dec_pkg::ST_OK,
		repeat_count != 8'd0)
	`RLE_ASSERT_SAME(a_early_form, out_valid_q && status == rle_dec_pkg::ST_EARLY,
		image_done && repeat_count == 8'd0 && pixel_value == 8'd0)
	`RLE_ASSERT_SAME(a_clip_closes, out_valid_q && status == rle_dec_pkg::ST_CLIP, image_done)

endmodule
